### rtl/line_sensor_position_error_defines.svh
// Assertion macros for the line sensor position error block.
// Used by line_sensor_position_error.sv; depends on nothing else.
`ifndef LINE_SENSOR_POSITION_ERROR_DEFINES_SVH
`define LINE_SENSOR_POSITION_ERROR_DEFINES_SVH

// Same-cycle implication.
`define LSPE_ASSERT_SAME(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("line sensor block: same-cycle check failed");

// Next-cycle implication.
`define LSPE_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("line sensor block: next-cycle check failed");

`endif

### rtl/lspe_pkg.sv
// Shared types, constants and helper functions of the line sensor position error block.
// Used by lspe_cell, lspe_ctrl and line_sensor_position_error; depends on nothing.
package lspe_pkg;

   localparam int SENSOR_COUNT  = 6;
   localparam int SAMPLE_BITS   = 12;
   localparam int FRAC_BITS     = 8;
   localparam int NUM_BITS      = SAMPLE_BITS + FRAC_BITS;
   localparam int LEVEL_BITS    = 12;
   localparam int LEVEL_LIMIT   = 2 ** (LEVEL_BITS - 1);
   localparam int THRESH_BITS   = LEVEL_BITS - 1;
   localparam int COUNT_BITS    = 10;
   localparam int KIND_BITS     = 2;
   localparam int ERROR_BITS    = 16;
   localparam int MASK_BITS     = SENSOR_COUNT;
   localparam int HALF_COUNT    = SENSOR_COUNT / 2;
   localparam int WEIGHT_BITS   = $clog2(HALF_COUNT + 1) + 1;
   localparam int SUM_RAW       = LEVEL_BITS + WEIGHT_BITS + $clog2(SENSOR_COUNT);
   localparam int SUM_BITS      = (SUM_RAW > ERROR_BITS) ? SUM_RAW : ERROR_BITS + 1;
   localparam int STEP_MAX      = (NUM_BITS > SENSOR_COUNT) ? NUM_BITS : SENSOR_COUNT;
   localparam int STEP_BITS     = $clog2(STEP_MAX);
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {SAMPLE_BITS{1'b1}};

   // Item kinds; kind 3 is ignored. The same codes report a commit.
   localparam logic [KIND_BITS-1:0] KIND_RUN   = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_WHITE = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_BLACK = 2'd2;
   localparam logic [KIND_BITS-1:0] DONE_NONE  = 2'd0;

   // Register index taken from paddr[2].
   localparam logic CSR_THRESHOLD = 1'b0;
   localparam logic CSR_COUNT     = 1'b1;

   localparam logic [THRESH_BITS-1:0] THRESHOLD_RESET = 11'd102;
   localparam logic [COUNT_BITS-1:0]  COUNT_RESET     = 10'd100;

   typedef struct packed {
      logic [KIND_BITS-1:0]   kind;
      logic [SAMPLE_BITS-1:0] sample_0;
      logic [SAMPLE_BITS-1:0] sample_1;
      logic [SAMPLE_BITS-1:0] sample_2;
      logic [SAMPLE_BITS-1:0] sample_3;
      logic [SAMPLE_BITS-1:0] sample_4;
      logic [SAMPLE_BITS-1:0] sample_5;
   } req_type;

   typedef struct packed {
      logic signed [ERROR_BITS-1:0] position_error;
      logic                         line_found;
      logic [MASK_BITS-1:0]         active_mask;
      logic [KIND_BITS-1:0]         calibration_done;
      logic signed [LEVEL_BITS-1:0] level_0;
      logic signed [LEVEL_BITS-1:0] level_1;
      logic signed [LEVEL_BITS-1:0] level_2;
      logic signed [LEVEL_BITS-1:0] level_3;
      logic signed [LEVEL_BITS-1:0] level_4;
      logic signed [LEVEL_BITS-1:0] level_5;
   } rsp_type;

   // Sequencer commands broadcast to every cell.
   typedef struct packed {
      logic load;
      logic step;
      logic sum_en;
      logic cal_update;
      logic cal_start;
      logic cal_commit;
      logic cal_white;
   } cell_ctl_type;

   // Sequencer report to the output stage.
   typedef struct packed {
      logic                 finish;
      logic                 run;
      logic [KIND_BITS-1:0] done;
   } ctrl_status_type;

   // Weights -3..3 left to right, no zero weight for an even count.
   function automatic logic signed [WEIGHT_BITS-1:0] sensor_weight(input int idx);
      int w;
      if ((SENSOR_COUNT % 2) == 0 && idx >= HALF_COUNT) begin
         w = idx - HALF_COUNT + 1;
      end else begin
         w = idx - HALF_COUNT;
      end
      return WEIGHT_BITS'(w);
   endfunction

endpackage

### rtl/lspe_cell.sv
// One sensor cell: calibration levels, bit-serial divider and one stage of the sum chain.
// Depends on lspe_pkg.
module lspe_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lspe_pkg::cell_ctl_type               ctl,
   input  logic [lspe_pkg::SAMPLE_BITS-1:0]     sample,
   input  logic [lspe_pkg::THRESH_BITS-1:0]     threshold,
   input  logic signed [lspe_pkg::WEIGHT_BITS-1:0] weight,
   input  logic signed [lspe_pkg::SUM_BITS-1:0] psum_prev,
   output logic signed [lspe_pkg::SUM_BITS-1:0] psum_out,
   output logic signed [lspe_pkg::LEVEL_BITS-1:0] level,
   output logic                                 active
);

   logic [lspe_pkg::SAMPLE_BITS-1:0] white_ff, white_in;
   logic [lspe_pkg::SAMPLE_BITS-1:0] black_ff, black_in;
   logic [lspe_pkg::SAMPLE_BITS-1:0] trk_ff, trk_in;
   logic [lspe_pkg::NUM_BITS-1:0]    nq_ff, nq_in;
   logic [lspe_pkg::SAMPLE_BITS-1:0] rem_ff, rem_in;
   logic                             neg_ff, neg_in;
   logic                             zero_ff, zero_in;
   logic signed [lspe_pkg::SUM_BITS-1:0] psum_ff, psum_in;

   logic [lspe_pkg::SAMPLE_BITS-1:0] mag;
   logic [lspe_pkg::SAMPLE_BITS:0]   rem_shift;
   logic [lspe_pkg::SAMPLE_BITS:0]   rem_diff;
   logic                             fits;
   logic [lspe_pkg::SAMPLE_BITS-1:0] trk_base;
   logic [lspe_pkg::SAMPLE_BITS-1:0] trk_upd;
   logic [lspe_pkg::LEVEL_BITS-1:0]  neg_q;

   // Magnitude and sign of sample minus black level.
   always_comb begin
      if (sample >= black_ff) begin
         mag = sample - black_ff;
      end else begin
         mag = black_ff - sample;
      end
   end

   // Restoring division, one quotient bit a cycle; quotient shifts in behind the dividend.
   assign rem_shift = {rem_ff, nq_ff[lspe_pkg::NUM_BITS-1]};
   assign rem_diff  = rem_shift - {1'b0, white_ff};
   assign fits      = rem_shift >= {1'b0, white_ff};

   always_comb begin
      nq_in   = nq_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      if (ctl.load) begin
         nq_in   = {mag, {lspe_pkg::FRAC_BITS{1'b0}}};
         rem_in  = '0;
         neg_in  = sample < black_ff;
         zero_in = mag == '0;
      end else if (ctl.step) begin
         nq_in  = {nq_ff[lspe_pkg::NUM_BITS-2:0], fits};
         rem_in = fits ? rem_diff[lspe_pkg::SAMPLE_BITS-1:0]
                       : rem_shift[lspe_pkg::SAMPLE_BITS-1:0];
      end
   end

   // Saturate the quotient to signed Q4.8; a zero numerator gives zero even for white 0.
   assign neg_q = ~nq_ff[lspe_pkg::LEVEL_BITS-1:0] + 1'b1;

   always_comb begin
      if (zero_ff) begin
         level = '0;
      end else if (!neg_ff) begin
         if (nq_ff > lspe_pkg::NUM_BITS'(lspe_pkg::LEVEL_LIMIT - 1)) begin
            level = lspe_pkg::LEVEL_BITS'(lspe_pkg::LEVEL_LIMIT - 1);
         end else begin
            level = nq_ff[lspe_pkg::LEVEL_BITS-1:0];
         end
      end else begin
         if (nq_ff > lspe_pkg::NUM_BITS'(lspe_pkg::LEVEL_LIMIT)) begin
            level = lspe_pkg::LEVEL_BITS'(lspe_pkg::LEVEL_LIMIT);
         end else begin
            level = neg_q;
         end
      end
   end

   assign active = $signed(level) > $signed({1'b0, threshold});

   // Sum chain: add own weighted level to the neighbor's partial sum.
   always_comb begin
      psum_in = psum_ff;
      if (ctl.sum_en) begin
         psum_in = psum_prev + lspe_pkg::SUM_BITS'(lspe_pkg::SUM_BITS'(weight)
                                                  * lspe_pkg::SUM_BITS'(level));
      end
   end

   assign psum_out = psum_ff;

   // Calibration tracker: restart on a new kind, then keep the maximum or minimum.
   always_comb begin
      if (ctl.cal_start) begin
         trk_base = ctl.cal_white ? '0 : lspe_pkg::FULL_SCALE;
      end else begin
         trk_base = trk_ff;
      end
      if (ctl.cal_white) begin
         trk_upd = (sample > trk_base) ? sample : trk_base;
      end else begin
         trk_upd = (sample < trk_base) ? sample : trk_base;
      end
      trk_in   = trk_ff;
      white_in = white_ff;
      black_in = black_ff;
      if (ctl.cal_update) begin
         trk_in = trk_upd;
         if (ctl.cal_commit) begin
            if (ctl.cal_white) begin
               white_in = trk_upd;
            end else begin
               black_in = trk_upd;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         white_ff <= lspe_pkg::FULL_SCALE;
         black_ff <= '0;
         trk_ff   <= '0;
      end else begin
         white_ff <= white_in;
         black_ff <= black_in;
         trk_ff   <= trk_in;
      end
   end

   always_ff @(posedge clock) begin
      nq_ff   <= nq_in;
      rem_ff  <= rem_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      psum_ff <= psum_in;
   end

endmodule

### rtl/lspe_ctrl.sv
// Sequencer: request acceptance, divide and sum phases, calibration progress and commit.
// Depends on lspe_pkg.
module lspe_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [lspe_pkg::KIND_BITS-1:0]      req_kind,
   input  logic                                out_free,
   input  logic [lspe_pkg::COUNT_BITS-1:0]     calibration_count,
   output lspe_pkg::cell_ctl_type              cell_ctl,
   output lspe_pkg::ctrl_status_type           status
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIVIDE = 4'b0010,
      ST_SUM    = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type                            state_ff, state_in;
   logic [lspe_pkg::STEP_BITS-1:0]       step_ff, step_in;
   logic [lspe_pkg::KIND_BITS-1:0]       cal_kind_ff, cal_kind_in;
   logic [lspe_pkg::COUNT_BITS-1:0]      progress_ff, progress_in;
   logic [lspe_pkg::KIND_BITS-1:0]       done_ff, done_in;
   logic                                 run_ff, run_in;

   logic                                 accept;
   logic                                 is_run;
   logic                                 is_cal;
   logic                                 cal_start;
   logic [lspe_pkg::COUNT_BITS-1:0]      prog_base;
   logic [lspe_pkg::COUNT_BITS-1:0]      prog_next;
   logic                                 commit;
   logic                                 last_div;
   logic                                 last_sum;

   assign req_ready = state_ff == ST_IDLE;
   assign accept    = req_valid && req_ready;
   assign is_run    = req_kind == lspe_pkg::KIND_RUN;
   assign is_cal    = (req_kind == lspe_pkg::KIND_WHITE) || (req_kind == lspe_pkg::KIND_BLACK);
   assign cal_start = cal_kind_ff != req_kind;
   assign prog_base = cal_start ? '0 : progress_ff;
   assign prog_next = prog_base + 1'b1;
   assign commit    = prog_next >= calibration_count;
   assign last_div  = step_ff == lspe_pkg::STEP_BITS'(lspe_pkg::NUM_BITS - 1);
   assign last_sum  = step_ff == lspe_pkg::STEP_BITS'(lspe_pkg::SENSOR_COUNT - 1);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      run_in   = run_ff;
      done_in  = done_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               step_in  = '0;
               run_in   = is_run;
               done_in  = (is_cal && commit) ? req_kind : lspe_pkg::DONE_NONE;
               state_in = is_run ? ST_DIVIDE : ST_FINISH;
            end
         end
         ST_DIVIDE: begin
            step_in = step_ff + 1'b1;
            if (last_div) begin
               step_in  = '0;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            step_in = step_ff + 1'b1;
            if (last_sum) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cal_kind_in = cal_kind_ff;
      progress_in = progress_ff;
      if (accept && is_cal) begin
         if (commit) begin
            cal_kind_in = lspe_pkg::DONE_NONE;
            progress_in = '0;
         end else begin
            cal_kind_in = req_kind;
            progress_in = prog_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         step_ff     <= '0;
         cal_kind_ff <= lspe_pkg::DONE_NONE;
         progress_ff <= '0;
         done_ff     <= lspe_pkg::DONE_NONE;
         run_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         step_ff     <= step_in;
         cal_kind_ff <= cal_kind_in;
         progress_ff <= progress_in;
         done_ff     <= done_in;
         run_ff      <= run_in;
      end
   end

   always_comb begin
      cell_ctl.load       = accept && is_run;
      cell_ctl.step       = state_ff == ST_DIVIDE;
      cell_ctl.sum_en     = state_ff == ST_SUM;
      cell_ctl.cal_update = accept && is_cal;
      cell_ctl.cal_start  = cal_start;
      cell_ctl.cal_commit = commit;
      cell_ctl.cal_white  = req_kind == lspe_pkg::KIND_WHITE;
      status.finish       = (state_ff == ST_FINISH) && out_free;
      status.run          = run_ff;
      status.done         = done_ff;
   end

endmodule

### rtl/line_sensor_position_error.sv
// Run request: 20 divide steps, one quotient bit a cycle in each cell, then the sum chain,
// then the output register. Requests of every kind are taken only in idle, so a new one
// is not taken until the sequencer has passed finish with the last one.
// A waiting result does not block the next request; it holds the sequencer only at finish.
// Synchronous active-high reset: white levels to full scale, black levels and trackers
// to zero, calibration idle, threshold 102 and calibration count 100.
`include "line_sensor_position_error_defines.svh"

module line_sensor_position_error (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  lspe_pkg::req_type                     req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output lspe_pkg::rsp_type                     rsp_payload,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [lspe_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [lspe_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [lspe_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                  csr_pready
);

   logic [lspe_pkg::THRESH_BITS-1:0] threshold_ff, threshold_in;
   logic [lspe_pkg::COUNT_BITS-1:0]  count_ff, count_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   lspe_pkg::rsp_type                rsp_payload_ff, rsp_payload_in;

   lspe_pkg::cell_ctl_type           cell_ctl;
   lspe_pkg::ctrl_status_type        status;
   logic                             out_free;
   logic                             csr_write;

   logic [lspe_pkg::SAMPLE_BITS-1:0]     samples [lspe_pkg::SENSOR_COUNT];
   logic signed [lspe_pkg::LEVEL_BITS-1:0] levels [lspe_pkg::SENSOR_COUNT];
   logic signed [lspe_pkg::SUM_BITS-1:0] psums [lspe_pkg::SENSOR_COUNT + 1];
   logic [lspe_pkg::MASK_BITS-1:0]       mask;
   logic signed [lspe_pkg::SUM_BITS-1:0] total;
   logic signed [lspe_pkg::ERROR_BITS-1:0] error_sat;

   localparam logic signed [lspe_pkg::SUM_BITS-1:0] ERR_MAX =
      lspe_pkg::SUM_BITS'(2 ** (lspe_pkg::ERROR_BITS - 1) - 1);
   localparam logic signed [lspe_pkg::SUM_BITS-1:0] ERR_MIN = ~ERR_MAX;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      threshold_in = threshold_ff;
      count_in     = count_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            lspe_pkg::CSR_THRESHOLD: threshold_in = csr_pwdata[lspe_pkg::THRESH_BITS-1:0];
            lspe_pkg::CSR_COUNT:     count_in     = csr_pwdata[lspe_pkg::COUNT_BITS-1:0];
            default:                 threshold_in = threshold_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         lspe_pkg::CSR_THRESHOLD:
            csr_prdata = lspe_pkg::CSR_DATA_BITS'(threshold_ff);
         lspe_pkg::CSR_COUNT:
            csr_prdata = lspe_pkg::CSR_DATA_BITS'(count_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   // Sequencer
   assign out_free = !rsp_valid_ff || rsp_ready;

   lspe_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_payload.kind),
      .out_free          (out_free),
      .calibration_count (count_ff),
      .cell_ctl          (cell_ctl),
      .status            (status)
   );

   // Row of sensor cells
   assign samples[0] = req_payload.sample_0;
   assign samples[1] = req_payload.sample_1;
   assign samples[2] = req_payload.sample_2;
   assign samples[3] = req_payload.sample_3;
   assign samples[4] = req_payload.sample_4;
   assign samples[5] = req_payload.sample_5;

   assign psums[0] = '0;

   for (genvar i = 0; i < lspe_pkg::SENSOR_COUNT; i++) begin : g_cell
      lspe_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (cell_ctl),
         .sample    (samples[i]),
         .threshold (threshold_ff),
         .weight    (lspe_pkg::sensor_weight(i)),
         .psum_prev (psums[i]),
         .psum_out  (psums[i+1]),
         .level     (levels[i]),
         .active    (mask[i])
      );
   end

   // Output stage
   assign total = psums[lspe_pkg::SENSOR_COUNT];

   always_comb begin
      if (total > ERR_MAX) begin
         error_sat = ERR_MAX[lspe_pkg::ERROR_BITS-1:0];
      end else if (total < ERR_MIN) begin
         error_sat = ERR_MIN[lspe_pkg::ERROR_BITS-1:0];
      end else begin
         error_sat = total[lspe_pkg::ERROR_BITS-1:0];
      end
   end

   always_comb begin
      rsp_payload_in = '0;
      if (status.run) begin
         rsp_payload_in.line_found     = |mask;
         rsp_payload_in.active_mask    = mask;
         rsp_payload_in.position_error = (|mask) ? error_sat : '0;
         rsp_payload_in.level_0        = levels[0];
         rsp_payload_in.level_1        = levels[1];
         rsp_payload_in.level_2        = levels[2];
         rsp_payload_in.level_3        = levels[3];
         rsp_payload_in.level_4        = levels[4];
         rsp_payload_in.level_5        = levels[5];
      end else begin
         rsp_payload_in.calibration_done = status.done;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (status.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= lspe_pkg::THRESHOLD_RESET;
         count_ff     <= lspe_pkg::COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         threshold_ff <= threshold_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (status.finish) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Checks
   `LSPE_ASSERT_NEXT(a_one_request_in_flight, clock, reset, req_valid && req_ready, !req_ready)
   `LSPE_ASSERT_SAME(a_found_matches_mask, clock, reset, rsp_valid, rsp_payload.line_found == (rsp_payload.active_mask != '0))
   `LSPE_ASSERT_SAME(a_commit_has_no_run_data, clock, reset, rsp_valid && rsp_payload.calibration_done != lspe_pkg::DONE_NONE, rsp_payload.active_mask == '0 && rsp_payload.position_error == '0)

endmodule

### sim/lspe_checker.sv
// Result checker for line_sensor_position_error: watches the request, result and register
// ports, predicts every result from its own copy of the block state and compares in order.
// Depends on lspe_pkg for the payload types, widths and codes.
module lspe_checker
   import lspe_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  req_type                  req_payload,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  rsp_type                  rsp_payload,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   input  logic [CSR_DATA_BITS-1:0] csr_prdata,
   input  logic                     csr_pready,
   output int                       pending,
   output int                       failures
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [SAMPLE_BITS-1:0] sample_row [SENSOR_COUNT];

   localparam int SIDE_WEIGHT [SENSOR_COUNT] = '{-3, -2, -1, 1, 2, 3};
   localparam int LEVEL_TOP = LEVEL_LIMIT - 1;
   localparam int LEVEL_BOTTOM = -LEVEL_LIMIT;

   logic [THRESH_BITS-1:0] threshold;
   logic [COUNT_BITS-1:0]  commit_count;
   logic [SAMPLE_BITS-1:0] white_lvl [SENSOR_COUNT];
   logic [SAMPLE_BITS-1:0] black_lvl [SENSOR_COUNT];
   logic [SAMPLE_BITS-1:0] extreme [SENSOR_COUNT];
   logic [COUNT_BITS-1:0]  progress;
   logic [KIND_BITS-1:0]   cal_kind;
   rsp_type                expected_results [$];

   task automatic report_error(input string msg);
      $display("%0t ns: %s", $time, msg);
      failures++;
   endtask

   task automatic compare_field(input string name, input longint got, input longint want);
      if (got != want) begin
         report_error($sformatf("%s is %0d, expected %0d", name, got, want));
      end
   endtask

   // (sample - black) / white in Q4.8, truncated toward zero, clamped to the level range
   function automatic int sensor_level(input logic [SAMPLE_BITS-1:0] s,
                                       input logic [SAMPLE_BITS-1:0] blk,
                                       input logic [SAMPLE_BITS-1:0] wht);
      longint num;
      longint quo;
      num = (longint'(s) - longint'(blk)) * (longint'(1) << FRAC_BITS);
      if (wht == '0) begin
         return (num > 0) ? LEVEL_TOP : ((num < 0) ? LEVEL_BOTTOM : 0);
      end
      quo = ((num < 0) ? -num : num) / longint'(wht);
      if (num < 0) quo = -quo;
      if (quo > LEVEL_TOP) quo = LEVEL_TOP;
      if (quo < LEVEL_BOTTOM) quo = LEVEL_BOTTOM;
      return int'(quo);
   endfunction

   function automatic rsp_type predict_result(input req_type r);
      rsp_type              res;
      sample_row            s;
      int                   lv [SENSOR_COUNT];
      int                   sum;
      logic [MASK_BITS-1:0] mask;
      res = '0;
      s = '{r.sample_0, r.sample_1, r.sample_2, r.sample_3, r.sample_4, r.sample_5};
      sum = 0;
      mask = '0;
      if (r.kind == KIND_RUN) begin
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            lv[i] = sensor_level(s[i], black_lvl[i], white_lvl[i]);
            if (lv[i] > int'(threshold)) mask[i] = 1'b1;
            sum += SIDE_WEIGHT[i] * lv[i];
         end
         if (sum > 32767) sum = 32767;
         if (sum < -32768) sum = -32768;
         if (mask != '0) begin
            res.position_error = ERROR_BITS'(sum);
            res.line_found = 1'b1;
         end
         res.active_mask = mask;
         res.level_0 = LEVEL_BITS'(lv[0]);
         res.level_1 = LEVEL_BITS'(lv[1]);
         res.level_2 = LEVEL_BITS'(lv[2]);
         res.level_3 = LEVEL_BITS'(lv[3]);
         res.level_4 = LEVEL_BITS'(lv[4]);
         res.level_5 = LEVEL_BITS'(lv[5]);
      end else if (r.kind == KIND_WHITE || r.kind == KIND_BLACK) begin
         // a change of kind restarts tracking from the opposite extreme
         if (cal_kind != r.kind) begin
            cal_kind = r.kind;
            progress = '0;
            for (int i = 0; i < SENSOR_COUNT; i++) begin
               extreme[i] = (r.kind == KIND_WHITE) ? '0 : FULL_SCALE;
            end
         end
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (r.kind == KIND_WHITE && s[i] > extreme[i]) extreme[i] = s[i];
            if (r.kind == KIND_BLACK && s[i] < extreme[i]) extreme[i] = s[i];
         end
         progress = progress + 1'b1;
         if (progress >= commit_count) begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
               if (r.kind == KIND_WHITE) white_lvl[i] = extreme[i];
               else black_lvl[i] = extreme[i];
            end
            res.calibration_done = r.kind;
            cal_kind = DONE_NONE;
            progress = '0;
         end
      end
      return res;
   endfunction

   task automatic compare_result(input rsp_type got, input rsp_type want);
      if ($isunknown(got)) begin
         report_error($sformatf("result has unknown bits: %h", got));
      end else begin
         compare_field("position_error", $signed(got.position_error),
                       $signed(want.position_error));
         compare_field("line_found", got.line_found, want.line_found);
         compare_field("active_mask", got.active_mask, want.active_mask);
         compare_field("calibration_done", got.calibration_done, want.calibration_done);
         compare_field("level_0", $signed(got.level_0), $signed(want.level_0));
         compare_field("level_1", $signed(got.level_1), $signed(want.level_1));
         compare_field("level_2", $signed(got.level_2), $signed(want.level_2));
         compare_field("level_3", $signed(got.level_3), $signed(want.level_3));
         compare_field("level_4", $signed(got.level_4), $signed(want.level_4));
         compare_field("level_5", $signed(got.level_5), $signed(want.level_5));
      end
   endtask

   always @(posedge clock) begin
      logic [CSR_DATA_BITS-1:0] reg_value;
      if (reset) begin
         threshold = THRESHOLD_RESET;
         commit_count = COUNT_RESET;
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            white_lvl[i] = FULL_SCALE;
            black_lvl[i] = '0;
            extreme[i] = '0;
         end
         progress = '0;
         cal_kind = DONE_NONE;
         expected_results.delete();
         failures = 0;
      end else begin
         // a result can never belong to a request taken at the same edge
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_error("result with no request waiting");
            end else begin
               compare_result(rsp_payload, expected_results.pop_front());
            end
         end
         if (req_valid && req_ready) begin
            expected_results.push_back(predict_result(req_payload));
         end
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr[2] == CSR_COUNT) commit_count = csr_pwdata[COUNT_BITS-1:0];
               else threshold = csr_pwdata[THRESH_BITS-1:0];
            end else begin
               reg_value = (csr_paddr[2] == CSR_COUNT) ? CSR_DATA_BITS'(commit_count)
                                                       : CSR_DATA_BITS'(threshold);
               if (csr_prdata !== reg_value) begin
                  report_error($sformatf("register read at %0d is %h, expected %h",
                                         csr_paddr, csr_prdata, reg_value));
               end
            end
         end
      end
      pending = expected_results.size();
   end

endmodule

### sim/tb.sv
// Testbench top for line_sensor_position_error: clock, reset, request and register
// stimulus with random stalls on both channels, and the final verdict.
// Depends on lspe_pkg, the block itself and lspe_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lspe_pkg::*;

   typedef logic [SAMPLE_BITS-1:0] sample_row [SENSOR_COUNT];

   localparam logic [KIND_BITS-1:0]   KIND_UNUSED   = 2'd3;
   localparam logic [THRESH_BITS-1:0] THRESHOLD_MAX = {THRESH_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0]  COUNT_MAX     = {COUNT_BITS{1'b1}};
   localparam int IDLE_PERCENT  = 23;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ITEMS  = 450;
   localparam int PHASE_ITEMS   = 45;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   req_type                  req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   rsp_type                  rsp_payload;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;
   int                       pending;
   int                       failures;
   int                       cycles = 0;
   bit                       quiet = 1'b0;
   int                       burst_len = 1;

   line_sensor_position_error dut (.*);
   lspe_checker u_checker (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("line_sensor_position_error test failed");
         $finish;
      end
   end

   // Called at a falling edge; returns at a falling edge with valid still high.
   task automatic push_request(input logic [KIND_BITS-1:0] kind, input sample_row s);
      while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{kind, s[0], s[1], s[2], s[3], s[4], s[5]};
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic idx,
                             input logic [CSR_DATA_BITS-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Drop valid, wait for every outstanding request, then let the pipeline empty.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure(input logic [THRESH_BITS-1:0] thr,
                            input logic [COUNT_BITS-1:0] cnt);
      drain_results();
      csr_access(1'b1, CSR_THRESHOLD, CSR_DATA_BITS'(thr));
      csr_access(1'b1, CSR_COUNT, CSR_DATA_BITS'(cnt));
      csr_access(1'b0, CSR_THRESHOLD, '0);
      csr_access(1'b0, CSR_COUNT, '0);
      burst_len = (cnt == '0) ? 1 : int'(cnt);
   endtask

   function automatic sample_row random_row(input int unsigned ceiling);
      sample_row s;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         case ($urandom_range(7))
            0: s[i] = '0;
            1: s[i] = SAMPLE_BITS'(ceiling);
            2: s[i] = SAMPLE_BITS'($urandom_range(0, ceiling / 16));
            default: s[i] = SAMPLE_BITS'($urandom_range(0, ceiling));
         endcase
      end
      return s;
   endfunction

   function automatic logic [THRESH_BITS-1:0] pick_threshold();
      case ($urandom_range(5))
         0: return '0;
         1: return THRESHOLD_MAX;
         2, 3: return THRESH_BITS'($urandom_range(0, 300));
         default: return THRESH_BITS'($urandom_range(0, THRESHOLD_MAX));
      endcase
   endfunction

   function automatic logic [COUNT_BITS-1:0] pick_count();
      case ($urandom_range(9))
         0: return '0;
         1: return COUNT_BITS'(1);
         8, 9: return COUNT_BITS'($urandom_range(7, 16));
         default: return COUNT_BITS'($urandom_range(2, 6));
      endcase
   endfunction

   initial begin
      int                     phase;
      int                     random_items;
      int                     phase_items;
      int                     choice;
      int                     len;
      int unsigned            ceiling;
      logic [KIND_BITS-1:0]   cal;
      logic [SAMPLE_BITS-1:0] flat;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset values of both registers
      csr_access(1'b0, CSR_THRESHOLD, '0);
      csr_access(1'b0, CSR_COUNT, '0);

      // no line, full-scale on all sensors, one edge sensor each side, ignored kind
      push_request(KIND_RUN, '{0, 0, 0, 0, 0, 0});
      push_request(KIND_RUN, '{FULL_SCALE, FULL_SCALE, FULL_SCALE, FULL_SCALE,
                               FULL_SCALE, FULL_SCALE});
      push_request(KIND_RUN, '{FULL_SCALE, 0, 0, 0, 0, 0});
      push_request(KIND_RUN, '{0, 0, 0, 0, 0, FULL_SCALE});
      push_request(KIND_UNUSED, random_row(FULL_SCALE));

      // count of zero commits every item; zero white levels saturate by the numerator sign
      configure(THRESHOLD_RESET, '0);
      push_request(KIND_WHITE, '{0, 16, FULL_SCALE, 1, 0, 100});
      push_request(KIND_RUN, '{0, FULL_SCALE, FULL_SCALE, 0, 5, 100});
      push_request(KIND_BLACK, '{10, FULL_SCALE, 0, 0, 0, 50});
      push_request(KIND_RUN, '{0, 0, 2048, 1, 0, 40});

      // highest threshold hides even saturated levels
      configure(THRESHOLD_MAX, '0);
      push_request(KIND_RUN, '{FULL_SCALE, FULL_SCALE, FULL_SCALE, FULL_SCALE,
                               FULL_SCALE, FULL_SCALE});

      // long calibration left open, run items pass through, kind change restarts it
      configure('0, COUNT_MAX);
      push_request(KIND_WHITE, random_row(FULL_SCALE));
      push_request(KIND_WHITE, random_row(FULL_SCALE));
      push_request(KIND_RUN, random_row(FULL_SCALE));
      push_request(KIND_BLACK, random_row(FULL_SCALE));
      push_request(KIND_BLACK, random_row(FULL_SCALE));

      // restore full-scale white and zero black
      configure(THRESHOLD_RESET, COUNT_BITS'(1));
      push_request(KIND_WHITE, '{FULL_SCALE, FULL_SCALE, FULL_SCALE, FULL_SCALE,
                                 FULL_SCALE, FULL_SCALE});
      push_request(KIND_BLACK, '{0, 0, 0, 0, 0, 0});

      configure(THRESHOLD_RESET, COUNT_BITS'(2));
      push_request(KIND_WHITE, '{2000, 2000, 2000, 2000, 2000, 2000});
      push_request(KIND_BLACK, '{100, 200, 300, 400, 500, 600});
      push_request(KIND_BLACK, '{50, 250, 350, 450, 550, 650});
      push_request(KIND_RUN, '{1000, 1500, 2100, 700, 0, FULL_SCALE});

      phase = 0;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         configure(pick_threshold(), pick_count());
         // one phase runs without any stalls on either side
         quiet <= (phase == 3);
         @(negedge clock);
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            choice = $urandom_range(99);
            if (choice < 50) begin
               push_request(KIND_RUN, random_row(FULL_SCALE));
               phase_items++;
            end else if (choice < 75) begin
               // full calibration, sometimes cut short
               cal = $urandom_range(1) ? KIND_WHITE : KIND_BLACK;
               ceiling = ($urandom_range(3) == 0) ? $urandom_range(0, 255) : FULL_SCALE;
               len = burst_len;
               if ($urandom_range(4) == 0) len = $urandom_range(1, burst_len);
               repeat (len) push_request(cal, random_row(ceiling));
               phase_items += len;
            end else if (choice < 87) begin
               cal = $urandom_range(1) ? KIND_WHITE : KIND_BLACK;
               push_request(cal, random_row(FULL_SCALE));
               phase_items++;
            end else if (choice < 92) begin
               push_request(KIND_UNUSED, random_row(FULL_SCALE));
            end else if (choice < 95) begin
               drain_results();
            end else begin
               flat = SAMPLE_BITS'($urandom_range(0, FULL_SCALE));
               push_request(KIND_RUN, '{flat, flat, flat, flat, flat, flat});
               phase_items++;
            end
         end
         random_items += phase_items;
         phase++;
      end

      drain_results();
      if (failures == 0) begin
         $display("line_sensor_position_error test passed");
      end else begin
         $display("line_sensor_position_error test failed");
      end
      $finish;
   end

endmodule
